>>> sv/lafk_pkg.sv
// Package for the legged arm forward kinematics block.
// Holds the fixed-point constants, the CORDIC arctangent table, the arm offsets and
// the shared types. Depends on nothing.
package lafk_pkg;

	localparam int ANGLE_FRAC_BITS = 13;
	localparam int POS_FRAC_BITS   = 16;
	localparam int CORDIC_STEPS    = 16;
	localparam int CORDIC_ITERS    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

	localparam int VW  = 26;
	localparam int MW  = 18;
	localparam int TW  = 20;
	localparam int AW  = 48;
	localparam int ZW  = 36;
	localparam int XW  = 34;
	localparam int ZSH = 30 - ANGLE_FRAC_BITS;

	localparam logic signed [ZW-1:0] PI_Z      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] TWO_PI_Z  = 36'sd6746518852;
	localparam logic signed [ZW-1:0] HALF_PI_Z = 36'sd1686629713;
	localparam logic signed [XW-1:0] GAIN_X    = 34'sd652032874;
	localparam logic signed [MW-1:0] ONE_T     = 18'sd65536;

	localparam logic signed [31:0] ATAN_TAB [24] = '{
		32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
		32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
		32'sd4194283, 32'sd2097149, 32'sd1048576, 32'sd524288,
		32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768,
		32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
		32'sd1024, 32'sd512, 32'sd256, 32'sd128
	};

	localparam int ARM_Q24 [8] = '{
		973079, 1207960, 648439, 834666, 4194304, 2936013, 1258291, 1426063
	};

	localparam int ARM_SH = 24 - POS_FRAC_BITS;

	localparam logic [2:0] REQ_POSE = 3'd0;
	localparam logic [2:0] REQ_FL   = 3'd1;
	localparam logic [2:0] REQ_FR   = 3'd2;
	localparam logic [2:0] REQ_RL   = 3'd3;
	localparam logic [2:0] REQ_RR   = 3'd4;
	localparam logic [2:0] REQ_ARM  = 3'd5;
	localparam logic [2:0] LIMB_ARM = 3'd4;

	localparam logic [2:0] REG_HIP_X   = 3'd0;
	localparam logic [2:0] REG_HIP_Y   = 3'd1;
	localparam logic [2:0] REG_THIGH_Y = 3'd2;
	localparam logic [2:0] REG_CALF    = 3'd3;
	localparam logic [2:0] REG_FOOT    = 3'd4;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_STEP, ST_REDUCE, ST_CORDIC, ST_ROUND,
		ST_BUILD, ST_MAC, ST_WB, ST_FINISH, ST_OUT
	} state_t;

	typedef enum logic [1:0] {MODE_MV_M, MODE_MV_B, MODE_MM_TM, MODE_MM_BM} mode_t;

	typedef enum logic [1:0] {KIND_POSE, KIND_LEG, KIND_ARM} kind_t;

	typedef struct packed {
		logic                 last;
		logic [1:0]           axis;
		logic [2:0]           asel;
		logic signed [VW-1:0] ox;
		logic signed [VW-1:0] oy;
		logic signed [VW-1:0] oz;
	} step_t;

	function automatic logic signed [VW-1:0] arm_c(input int k);
		return VW'((ARM_Q24[k] + (1 << (ARM_SH - 1))) >>> ARM_SH);
	endfunction

endpackage

>>> sv/legged_arm_forward_kinematics.sv
// Top level of the legged arm forward kinematics block.
// Holds the sequencer, the CORDIC rotator and the shared multiply-accumulate unit.
// Depends on lafk_pkg.
//
// A pose transaction stores the body rotation and base position and gives no result;
// a leg or arm transaction gives one tip position. Each joint takes one CORDIC run of
// 16 iterations after the angle reduction, and one 3x3 matrix-vector product on the
// single multiply-accumulate unit. A pose takes two 3x3 matrix products. The input is
// ready only when the sequencer is idle; a finished result waits in the output register.
module legged_arm_forward_kinematics
	import lafk_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// angle_0..angle_5 (16 bits each), base_x, base_y, base_z (24 bits each)
	input  logic [167:0] s_axis_tdata,
	// req_type
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x, pos_y, pos_z (24 bits each)
	output logic [71:0]  m_axis_tdata,
	// limb
	output logic [2:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [14:0]  cfg_wdata
);

	state_t state_q, state_d;
	mode_t  mode_q;
	kind_t  kind_q;

	logic [14:0] hip_x_q, hip_y_q, thigh_y_q, calf_q, foot_q;
	logic signed [MW-1:0] body_q [9];
	logic signed [23:0]   base_q [3];
	logic signed [MW-1:0] m_q [9];
	logic signed [TW-1:0] t_q [9];
	logic signed [VW-1:0] v_q [3];
	logic signed [VW-1:0] vt_q [3];
	logic signed [15:0]   ang_q [6];
	logic [2:0] step_q, limb_q;
	logic       rear_q, right_q, neg_q;
	logic [1:0] axis_q;
	logic signed [ZW-1:0] z_q;
	logic signed [XW-1:0] x_q, y_q;
	logic [4:0] iter_q;
	logic signed [MW-1:0] sin_q, cos_q;
	logic [1:0] r_q, c_q, k_q;
	logic signed [AW-1:0] acc_q;
	logic m_valid_q;
	logic [2:0] m_limb_q;
	logic signed [23:0] m_pos_q [3];

	step_t desc;
	logic signed [ZW-1:0] z_init;
	logic z_hi, z_lo;
	logic signed [XW-1:0] dx, dy, xr, yr;
	logic signed [MW-1:0] xs, ys;
	logic signed [MW-1:0] m_new [9];
	logic [3:0] idx_a, idx_b, idx_o;
	logic signed [TW-1:0] mul_a;
	logic signed [VW-1:0] mul_b;
	logic signed [AW-1:0] prod, acc_r;
	logic accept, out_free, wb_done;
	logic signed [26:0] osum [3];
	logic signed [23:0] osat [3];

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_limb_q;
	assign m_axis_tdata  = {m_pos_q[2], m_pos_q[1], m_pos_q[0]};

	always_comb begin
		desc = '0;
		unique case (kind_q)
			KIND_LEG: begin
				unique case (step_q)
					3'd0: begin
						desc.axis = AXIS_Y;
						desc.asel = 3'd2;
						desc.oz   = -$signed({11'b0, foot_q});
					end
					3'd1: begin
						desc.axis = AXIS_Y;
						desc.asel = 3'd1;
						desc.oz   = -$signed({11'b0, calf_q});
					end
					3'd2: begin
						desc.axis = AXIS_X;
						desc.asel = 3'd0;
						desc.oy   = right_q ? -$signed({11'b0, thigh_y_q})
							: $signed({11'b0, thigh_y_q});
					end
					default: begin
						desc.last = 1'b1;
						desc.ox   = rear_q ? -$signed({11'b0, hip_x_q})
							: $signed({11'b0, hip_x_q});
						desc.oy   = right_q ? -$signed({11'b0, hip_y_q})
							: $signed({11'b0, hip_y_q});
					end
				endcase
			end
			KIND_ARM: begin
				unique case (step_q)
					3'd0: begin
						desc.axis = AXIS_X;
						desc.asel = 3'd5;
						desc.ox   = arm_c(7);
					end
					3'd1: begin
						desc.axis = AXIS_Y;
						desc.asel = 3'd4;
						desc.ox   = arm_c(6);
					end
					3'd2: begin
						desc.axis = AXIS_X;
						desc.asel = 3'd3;
						desc.ox   = arm_c(5);
					end
					3'd3: begin
						desc.axis = AXIS_Y;
						desc.asel = 3'd2;
						desc.ox   = arm_c(3);
						desc.oz   = arm_c(4);
					end
					3'd4: begin
						desc.axis = AXIS_Y;
						desc.asel = 3'd1;
						desc.oz   = arm_c(2);
					end
					3'd5: begin
						desc.axis = AXIS_Z;
						desc.asel = 3'd0;
						desc.oz   = arm_c(1);
					end
					default: begin
						desc.last = 1'b1;
						desc.oz   = arm_c(0);
					end
				endcase
			end
			default: begin
				unique case (step_q)
					3'd0: begin
						desc.axis = AXIS_Z;
						desc.asel = 3'd2;
					end
					3'd1: begin
						desc.axis = AXIS_Y;
						desc.asel = 3'd1;
					end
					default: begin
						desc.axis = AXIS_X;
						desc.asel = 3'd0;
					end
				endcase
			end
		endcase
	end

	always_comb begin
		z_init = ZW'($signed(ang_q[desc.asel[2:0] > 3'd5 ? 3'd0 : desc.asel])) <<< ZSH;
		z_hi   = (z_q > PI_Z);
		z_lo   = (z_q < -PI_Z);
		dx     = y_q >>> iter_q;
		dy     = x_q >>> iter_q;
		xr     = (x_q + XW'(8192)) >>> 14;
		yr     = (y_q + XW'(8192)) >>> 14;
		xs     = (xr > XW'(65536)) ? ONE_T : ((xr < -XW'(65536)) ? -ONE_T : MW'(xr));
		ys     = (yr > XW'(65536)) ? ONE_T : ((yr < -XW'(65536)) ? -ONE_T : MW'(yr));
	end

	always_comb begin
		for (int i = 0; i < 9; i++)
			m_new[i] = '0;
		unique case (axis_q)
			AXIS_X: begin
				m_new[0] = ONE_T;
				m_new[4] = cos_q;
				m_new[5] = -sin_q;
				m_new[7] = sin_q;
				m_new[8] = cos_q;
			end
			AXIS_Y: begin
				m_new[0] = cos_q;
				m_new[2] = sin_q;
				m_new[4] = ONE_T;
				m_new[6] = -sin_q;
				m_new[8] = cos_q;
			end
			default: begin
				m_new[0] = cos_q;
				m_new[1] = -sin_q;
				m_new[3] = sin_q;
				m_new[4] = cos_q;
				m_new[8] = ONE_T;
			end
		endcase
	end

	always_comb begin
		idx_a = 4'({2'b0, r_q} * 4'd3) + 4'(k_q);
		idx_b = 4'({2'b0, k_q} * 4'd3) + 4'(c_q);
		idx_o = 4'({2'b0, r_q} * 4'd3) + 4'(c_q);
		unique case (mode_q)
			MODE_MV_M: begin
				mul_a = TW'(m_q[idx_a]);
				mul_b = v_q[k_q];
			end
			MODE_MV_B: begin
				mul_a = TW'(body_q[idx_a]);
				mul_b = v_q[k_q];
			end
			MODE_MM_TM: begin
				mul_a = t_q[idx_a];
				mul_b = VW'(m_q[idx_b]);
			end
			default: begin
				mul_a = TW'(body_q[idx_a]);
				mul_b = VW'(m_q[idx_b]);
			end
		endcase
		prod    = AW'(mul_a) * AW'(mul_b);
		acc_r   = (acc_q + AW'(32768)) >>> 16;
		wb_done = (r_q == 2'd2) &&
			(mode_q == MODE_MV_M || mode_q == MODE_MV_B || c_q == 2'd2);
		for (int i = 0; i < 3; i++) begin
			osum[i] = 27'(vt_q[i]) + 27'(base_q[i]);
			osat[i] = (osum[i] > 27'sd8388607) ? 24'sd8388607
				: ((osum[i] < -27'sd8388608) ? -24'sd8388608 : 24'(osum[i]));
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_axis_tuser <= REQ_ARM)
					state_d = ST_STEP;
			end
			ST_STEP:   state_d = desc.last ? ST_MAC : ST_REDUCE;
			ST_REDUCE: begin
				if (!z_hi && !z_lo)
					state_d = ST_CORDIC;
			end
			ST_CORDIC: begin
				if (iter_q == 5'(CORDIC_ITERS - 1))
					state_d = ST_ROUND;
			end
			ST_ROUND:  state_d = ST_BUILD;
			ST_BUILD:  state_d = (kind_q == KIND_POSE && step_q == 3'd0) ? ST_STEP : ST_MAC;
			ST_MAC: begin
				if (k_q == 2'd2)
					state_d = ST_WB;
			end
			ST_WB:     state_d = wb_done ? ST_FINISH : ST_MAC;
			ST_FINISH: begin
				unique case (mode_q)
					MODE_MV_B:  state_d = ST_OUT;
					MODE_MM_BM: state_d = ST_IDLE;
					default:    state_d = ST_STEP;
				endcase
			end
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			m_limb_q  <= '0;
			hip_x_q   <= 15'd12327;
			hip_y_q   <= 15'd3064;
			thigh_y_q <= 15'd5243;
			calf_q    <= 15'd13959;
			foot_q    <= 15'd13959;
			for (int i = 0; i < 9; i++)
				body_q[i] <= (i % 4 == 0) ? ONE_T : '0;
			for (int i = 0; i < 3; i++) begin
				base_q[i]  <= '0;
				m_pos_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_HIP_X:   hip_x_q   <= cfg_wdata;
					REG_HIP_Y:   hip_y_q   <= cfg_wdata;
					REG_THIGH_Y: thigh_y_q <= cfg_wdata;
					REG_CALF:    calf_q    <= cfg_wdata;
					REG_FOOT:    foot_q    <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && accept && s_axis_tuser == REQ_POSE) begin
				base_q[0] <= s_axis_tdata[119:96];
				base_q[1] <= s_axis_tdata[143:120];
				base_q[2] <= s_axis_tdata[167:144];
			end
			if (state_q == ST_WB && mode_q == MODE_MM_TM)
				body_q[idx_o] <= MW'(acc_r);
			if (state_q == ST_FINISH && mode_q == MODE_MM_BM) begin
				for (int i = 0; i < 9; i++)
					body_q[i] <= (t_q[i] > TW'(131071)) ? 18'sd131071
						: ((t_q[i] < -TW'(131072)) ? -18'sd131072 : MW'(t_q[i]));
			end
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
				m_limb_q  <= limb_q;
				for (int i = 0; i < 3; i++)
					m_pos_q[i] <= osat[i];
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < 6; i++)
					ang_q[i] <= s_axis_tdata[16*i +: 16];
				for (int i = 0; i < 3; i++)
					v_q[i] <= '0;
				step_q  <= '0;
				rear_q  <= (s_axis_tuser == REQ_RL || s_axis_tuser == REQ_RR);
				right_q <= (s_axis_tuser == REQ_FR || s_axis_tuser == REQ_RR);
				limb_q  <= (s_axis_tuser == REQ_ARM) ? LIMB_ARM : s_axis_tuser - 3'd1;
				kind_q  <= (s_axis_tuser == REQ_POSE) ? KIND_POSE
					: ((s_axis_tuser == REQ_ARM) ? KIND_ARM : KIND_LEG);
			end
			ST_STEP: begin
				v_q[0] <= v_q[0] + desc.ox;
				v_q[1] <= v_q[1] + desc.oy;
				v_q[2] <= v_q[2] + desc.oz;
				axis_q <= desc.axis;
				z_q    <= z_init;
				x_q    <= GAIN_X;
				y_q    <= '0;
				neg_q  <= 1'b0;
				iter_q <= '0;
				mode_q <= MODE_MV_B;
				r_q    <= '0;
				c_q    <= '0;
				k_q    <= '0;
			end
			ST_REDUCE: begin
				if (z_hi)
					z_q <= z_q - TWO_PI_Z;
				else if (z_lo)
					z_q <= z_q + TWO_PI_Z;
				else if (z_q > HALF_PI_Z) begin
					z_q   <= z_q - PI_Z;
					neg_q <= 1'b1;
				end else if (z_q < -HALF_PI_Z) begin
					z_q   <= z_q + PI_Z;
					neg_q <= 1'b1;
				end
			end
			ST_CORDIC: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - ZW'(ATAN_TAB[iter_q]);
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + ZW'(ATAN_TAB[iter_q]);
				end
				iter_q <= iter_q + 5'd1;
			end
			ST_ROUND: begin
				cos_q <= neg_q ? -xs : xs;
				sin_q <= neg_q ? -ys : ys;
			end
			ST_BUILD: begin
				for (int i = 0; i < 9; i++)
					m_q[i] <= m_new[i];
				if (kind_q == KIND_POSE) begin
					unique case (step_q)
						3'd0: begin
							step_q <= 3'd1;
							t_q[0] <= TW'(cos_q);
							t_q[1] <= TW'(-sin_q);
							t_q[2] <= '0;
							t_q[3] <= TW'(sin_q);
							t_q[4] <= TW'(cos_q);
							t_q[5] <= '0;
							t_q[6] <= '0;
							t_q[7] <= '0;
							t_q[8] <= TW'(ONE_T);
						end
						3'd1:    mode_q <= MODE_MM_TM;
						default: mode_q <= MODE_MM_BM;
					endcase
				end else begin
					mode_q <= MODE_MV_M;
				end
			end
			ST_MAC: begin
				acc_q <= ((k_q == 2'd0) ? '0 : acc_q) + prod;
				if (k_q != 2'd2)
					k_q <= k_q + 2'd1;
			end
			ST_WB: begin
				k_q <= '0;
				if (mode_q == MODE_MV_M || mode_q == MODE_MV_B) begin
					vt_q[r_q] <= VW'(acc_r);
					r_q       <= r_q + 2'd1;
				end else begin
					if (mode_q == MODE_MM_BM)
						t_q[idx_o] <= TW'(acc_r);
					if (c_q == 2'd2) begin
						c_q <= '0;
						r_q <= r_q + 2'd1;
					end else begin
						c_q <= c_q + 2'd1;
					end
				end
			end
			ST_FINISH: begin
				r_q <= '0;
				c_q <= '0;
				if (mode_q == MODE_MV_M) begin
					for (int i = 0; i < 3; i++)
						v_q[i] <= vt_q[i];
				end
				step_q <= step_q + 3'd1;
			end
			default: ;
		endcase
	end

	a_out_not_pose: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> kind_q != KIND_POSE)
		else $error("result stage reached for a pose transaction");

	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORDIC |-> iter_q < 5'(CORDIC_ITERS))
		else $error("CORDIC iteration count out of range");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output stage");

	a_mac_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> (r_q != 2'd3 && c_q != 2'd3 && k_q != 2'd3))
		else $error("multiply-accumulate index out of range");

endmodule

>>> tb/sv/tb_legged_arm_forward_kinematics.sv
// Testbench for legged_arm_forward_kinematics: drives pose, leg and arm transactions with
// random idling and stalls, predicts foot and end-effector positions, and checks each result.
// Depends on lafk_pkg and the block's RTL.
module tb_legged_arm_forward_kinematics;
	import lafk_pkg::*;

	typedef struct {
		logic [2:0]  limb;
		logic [23:0] px;
		logic [23:0] py;
		logic [23:0] pz;
	} tip_t;

	localparam longint ONE = 64'sd65536;
	localparam longint PI_L = 64'sd3373259426;
	localparam longint TWO_PI_L = 64'sd6746518852;
	localparam longint HALF_PI_L = 64'sd1686629713;
	localparam longint GAIN_L = 64'sd652032874;

	class kinematics_scoreboard;
		longint body_rot[9];
		longint base_pos[3];
		longint hip_x, hip_y, thigh_y, calf_len, foot_len;
		tip_t tips_due[$];
		int mismatches;
		int checked;

		function void reset_state();
			for (int i = 0; i < 9; i++) body_rot[i] = (i % 4 == 0) ? ONE : 0;
			for (int i = 0; i < 3; i++) base_pos[i] = 0;
			hip_x = 12327; hip_y = 3064; thigh_y = 5243; calf_len = 13959; foot_len = 13959;
			mismatches = 0;
			checked = 0;
		endfunction

		function longint round16(longint v);
			return (v + 64'sd32768) >>> 16;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void sin_cos(logic signed [15:0] a, output longint s, output longint c);
			longint z, x, y, dx, dy, t;
			bit neg;
			z = longint'(a) * (64'sd1 <<< (30 - ANGLE_FRAC_BITS));
			x = GAIN_L;
			y = 0;
			neg = 0;
			for (int i = 0; i < 16; i++) begin
				if (z > PI_L) z -= TWO_PI_L;
				else if (z < -PI_L) z += TWO_PI_L;
			end
			if (z > HALF_PI_L) begin
				z -= PI_L; neg = 1;
			end else if (z < -HALF_PI_L) begin
				z += PI_L; neg = 1;
			end
			for (int i = 0; i < CORDIC_ITERS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				t = longint'(ATAN_TAB[i]);
				if (z >= 0) begin
					x -= dx; y += dy; z -= t;
				end else begin
					x += dx; y -= dy; z += t;
				end
			end
			x = clip((x + 64'sd8192) >>> 14, -ONE, ONE);
			y = clip((y + 64'sd8192) >>> 14, -ONE, ONE);
			c = neg ? -x : x;
			s = neg ? -y : y;
		endfunction

		function void axis_matrix(logic [1:0] ax, logic signed [15:0] a, output longint m[9]);
			longint s, c;
			sin_cos(a, s, c);
			for (int i = 0; i < 9; i++) m[i] = 0;
			if (ax == AXIS_X) begin
				m[0] = ONE; m[4] = c; m[5] = -s; m[7] = s; m[8] = c;
			end else if (ax == AXIS_Y) begin
				m[0] = c; m[2] = s; m[4] = ONE; m[6] = -s; m[8] = c;
			end else begin
				m[0] = c; m[1] = -s; m[3] = s; m[4] = c; m[8] = ONE;
			end
		endfunction

		function void mat_mul(longint a[9], longint b[9], output longint o[9]);
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					o[3*r+k] = round16(a[3*r]*b[k] + a[3*r+1]*b[3+k] + a[3*r+2]*b[6+k]);
		endfunction

		function void mat_vec(longint m[9], inout longint v[3]);
			longint t[3];
			for (int r = 0; r < 3; r++)
				t[r] = round16(m[3*r]*v[0] + m[3*r+1]*v[1] + m[3*r+2]*v[2]);
			v = t;
		endfunction

		function void rotate_joint(logic [1:0] ax, logic signed [15:0] a, inout longint v[3],
				input longint ox, longint oy, longint oz);
			longint m[9];
			v[0] += ox; v[1] += oy; v[2] += oz;
			axis_matrix(ax, a, m);
			mat_vec(m, v);
		endfunction

		function longint arm_offset(int k);
			return (longint'(ARM_Q24[k]) + (64'sd1 <<< (ARM_SH - 1))) >>> ARM_SH;
		endfunction

		function void write_reg(logic [2:0] idx, logic [14:0] val);
			case (idx)
				REG_HIP_X: hip_x = val;
				REG_HIP_Y: hip_y = val;
				REG_THIGH_Y: thigh_y = val;
				REG_CALF: calf_len = val;
				REG_FOOT: foot_len = val;
				default: ;
			endcase
		endfunction

		function void note_request(logic [2:0] rt, logic signed [15:0] ang[6],
				logic signed [23:0] bx, logic signed [23:0] by, logic signed [23:0] bz);
			longint v[3], mz[9], my[9], mx[9], t[9], r[9], hx, hy, ty, p[3];
			tip_t tip;
			if (rt > REQ_ARM) return;
			if (rt == REQ_POSE) begin
				axis_matrix(AXIS_Z, ang[2], mz);
				axis_matrix(AXIS_Y, ang[1], my);
				axis_matrix(AXIS_X, ang[0], mx);
				mat_mul(mz, my, t);
				mat_mul(t, mx, r);
				for (int i = 0; i < 9; i++) body_rot[i] = clip(r[i], -131072, 131071);
				base_pos[0] = bx; base_pos[1] = by; base_pos[2] = bz;
				return;
			end
			v = '{0, 0, 0};
			if (rt != REQ_ARM) begin
				hx = (rt == REQ_RL || rt == REQ_RR) ? -hip_x : hip_x;
				hy = (rt == REQ_FR || rt == REQ_RR) ? -hip_y : hip_y;
				ty = (rt == REQ_FR || rt == REQ_RR) ? -thigh_y : thigh_y;
				rotate_joint(AXIS_Y, ang[2], v, 0, 0, -foot_len);
				rotate_joint(AXIS_Y, ang[1], v, 0, 0, -calf_len);
				rotate_joint(AXIS_X, ang[0], v, 0, ty, 0);
				v[0] += hx; v[1] += hy;
				tip.limb = rt - 3'd1;
			end else begin
				rotate_joint(AXIS_X, ang[5], v, arm_offset(7), 0, 0);
				rotate_joint(AXIS_Y, ang[4], v, arm_offset(6), 0, 0);
				rotate_joint(AXIS_X, ang[3], v, arm_offset(5), 0, 0);
				rotate_joint(AXIS_Y, ang[2], v, arm_offset(3), 0, arm_offset(4));
				rotate_joint(AXIS_Y, ang[1], v, 0, 0, arm_offset(2));
				rotate_joint(AXIS_Z, ang[0], v, 0, 0, arm_offset(1));
				v[2] += arm_offset(0);
				tip.limb = LIMB_ARM;
			end
			mat_vec(body_rot, v);
			for (int i = 0; i < 3; i++) p[i] = clip(v[i] + base_pos[i], -8388608, 8388607);
			tip.px = p[0][23:0]; tip.py = p[1][23:0]; tip.pz = p[2][23:0];
			tips_due.push_back(tip);
		endfunction

		function void check_tip(logic [2:0] limb, logic [71:0] data);
			tip_t e;
			if (tips_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result limb=%0d data=%h", limb, data);
				return;
			end
			e = tips_due.pop_front();
			checked++;
			if (e.limb !== limb || e.px !== data[23:0] || e.py !== data[47:24]
					|| e.pz !== data[71:48]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected limb=%0d x=%h y=%h z=%h, got limb=%0d x=%h y=%h z=%h",
						e.limb, e.px, e.py, e.pz, limb, data[23:0], data[47:24], data[71:48]);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [167:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         cfg_we;
	logic [2:0]   cfg_addr;
	logic [14:0]  cfg_wdata;

	kinematics_scoreboard sb;
	int  sent;
	int  long_hold;
	bit  stall_mode;

	legged_arm_forward_kinematics u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_request(logic [2:0] rt, logic signed [15:0] ang[6],
			logic signed [23:0] bx, logic signed [23:0] by, logic signed [23:0] bz);
		s_axis_tvalid <= 1;
		s_axis_tuser <= rt;
		s_axis_tdata <= {bz, by, bx, ang[5], ang[4], ang[3], ang[2], ang[1], ang[0]};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(rt, ang, bx, by, bz);
		sent++;
		@(negedge clk);
	endtask

	task automatic gap_cycles(int n);
		s_axis_tvalid <= 0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_angle(bit wild);
		if (wild) return 16'($urandom);
		case ($urandom_range(0, 5))
			0: return -16'sd25736;
			1: return 16'sd25736;
			default: return 16'($signed($urandom_range(0, 51472)) - 25736);
		endcase
	endfunction

	function automatic logic signed [23:0] rand_base();
		if ($urandom_range(0, 7) == 0) return 24'($urandom);
		return 24'($signed($urandom_range(0, 16646144)) - 8323072);
	endfunction

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (sb.tips_due.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [14:0] val);
		cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic random_phase(int count);
		logic signed [15:0] ang[6];
		int burst;
		bit wild;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			wild = ($urandom_range(0, 9) == 0);
			for (int k = 0; k < 6; k++) ang[k] = rand_angle(wild);
			if (burst == 0) begin
				if ($urandom_range(0, 3) == 0) gap_cycles($urandom_range(1, 300));
				burst = $urandom_range(1, 12);
			end
			burst--;
			send_request($urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5)), ang, rand_base(), rand_base(), rand_base());
		end
	endtask

	// Receiver: random stall pattern, with long holds requested by the stimulus.
	always @(negedge clk) begin
		if (!arst_n) m_axis_tready <= 0;
		else if (long_hold > 0) begin
			m_axis_tready <= 0;
			long_hold <= long_hold - 1;
		end else if (stall_mode) m_axis_tready <= ($urandom_range(0, 3) != 0);
		else m_axis_tready <= 1;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_tip(m_axis_tuser, m_axis_tdata);
	end

	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
	end

	initial begin
		logic signed [15:0] ang[6];
		logic signed [15:0] edges[4];
		sb = new();
		sb.reset_state();
		sent = 0;
		long_hold = 0;
		stall_mode = 1;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_POSE;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_addr = REG_HIP_X;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: every leg and arm request at reset pose, angle extremes, out-of-range
		// angles, saturating base positions and unused request codes.
		edges = '{16'sd0, -16'sd25736, 16'sd25736, -16'sd32768};
		ang = '{0, 0, 0, 0, 0, 0};
		for (int r = REQ_FL; r <= REQ_ARM; r++) send_request(3'(r), ang, 0, 0, 0);
		for (int e = 1; e < 4; e++) begin
			for (int k = 0; k < 6; k++) ang[k] = edges[e];
			send_request(REQ_POSE, ang, 24'sh7FFFFF, -24'sh800000, 24'sd8323072);
			send_request(REQ_FL, ang, 0, 0, 0);
			send_request(REQ_RR, ang, 0, 0, 0);
			send_request(REQ_ARM, ang, 0, 0, 0);
		end
		ang = '{16'sh7FFF, 16'sh4000, -16'sh4000, 16'sh1234, -16'sh7FFF, 16'sh6487};
		send_request(3'd6, ang, 0, 0, 0);
		send_request(3'd7, ang, 0, 0, 0);
		send_request(REQ_POSE, ang, -24'sd8323072, 24'sd8323072, -24'sd8323072);
		send_request(REQ_FR, ang, 0, 0, 0);
		send_request(REQ_RL, ang, 0, 0, 0);
		wait_drained();

		// Long receiver hold while the sender keeps offering.
		long_hold = 2000;
		random_phase(20);
		wait_drained();

		random_phase(200);
		wait_drained();

		// Configuration settings: all-max, all-zero, then random.
		for (int i = 0; i <= REG_FOOT; i++) write_cfg(3'(i), 15'h7FFF);
		write_cfg(3'd7, 15'h1234);
		random_phase(150);
		wait_drained();
		for (int i = 0; i <= REG_FOOT; i++) write_cfg(3'(i), 15'h0000);
		random_phase(120);
		wait_drained();
		for (int i = 0; i <= REG_FOOT; i++) write_cfg(3'(i), 15'($urandom));
		random_phase(240);
		wait_drained();

		$display("Sent %0d requests over four register settings; %0d tip positions checked.",
			sent, sb.checked);
		if (sb.mismatches == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
